// ===== sv/wft_pkg.sv =====
package wft_pkg;

   localparam int MAX_FRAME_BITS = 64;
   localparam int BITS_W = $clog2(MAX_FRAME_BITS + 1);

   localparam int PULSE_W = 16;
   localparam int GAP_W = 16;
   localparam int FRAME_BITS_W = 7;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int VALUE_W = 64;

   localparam logic [PULSE_W-1:0] PULSE_RESET = PULSE_W'(400);
   localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(1600);
   localparam logic [FRAME_BITS_W-1:0] FRAME_BITS_RESET =
      FRAME_BITS_W'((26 < MAX_FRAME_BITS) ? 26 : MAX_FRAME_BITS);

   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_WIDTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAP_WIDTH = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_BITS = 2'd2;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_START = 1'b1;

   typedef enum logic [1:0] {
      PHASE_IDLE = 2'd0,
      PHASE_PULSE = 2'd1,
      PHASE_GAP = 2'd2
   } phase_type;

endpackage

// ===== sv/wiegand_frame_transmitter_core.sv =====
// The result word for an input word is registered and valid in the cycle after accept.
// Throughput: one word per cycle unless stalled; line state and timers update on accept.
// The input stalls only while a finished result waits and the result side stalls.
// Reset (synchronous, active high) returns to idle and clears rsp_valid, but not the line
// outputs, and sets the registers to pulse_width 400, gap_width 1600 and frame_bits 26.
module wiegand_frame_transmitter_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [wft_pkg::VALUE_W-1:0]         req_frame_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_zero_line,
   output logic                                rsp_one_line,
   output logic                                rsp_busy_res,
   output logic                                rsp_frame_done,
   output logic                                rsp_start_ignored,
   input  logic                                csr_write,
   input  logic [wft_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [wft_pkg::CSR_DATA_W-1:0]      csr_data
);

   localparam int MAXB = wft_pkg::MAX_FRAME_BITS;
   localparam int BW = wft_pkg::BITS_W;

   logic [wft_pkg::PULSE_W-1:0]      pulse_width_ff;
   logic [wft_pkg::GAP_W-1:0]        gap_width_ff;
   logic [wft_pkg::FRAME_BITS_W-1:0] frame_bits_ff;

   wft_pkg::phase_type phase_ff, phase_in;
   logic [MAXB-1:0]    shift_word_ff, shift_word_in;
   logic [BW-1:0]      bits_left_ff, bits_left_in;
   logic [15:0]        time_left_ff, time_left_in;

   logic rsp_valid_ff;
   logic zero_line_ff, zero_line_in;
   logic one_line_ff, one_line_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic ignored_ff, ignored_in;

   logic            accept;
   logic [15:0]     time_dec;
   logic [BW-1:0]   start_bits;
   logic [BW-1:0]   shift_amt;
   logic            busy_now;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept = req_valid && !req_stall;
   assign busy_now = (phase_ff == wft_pkg::PHASE_PULSE) || (phase_ff == wft_pkg::PHASE_GAP);
   assign time_dec = time_left_ff - 16'd1;

   // The register write already keeps frame_bits in range, so no clamp is needed here.
   assign start_bits = BW'(frame_bits_ff);
   assign shift_amt = BW'(MAXB) - start_bits;

   // Config registers drop zero widths and frame lengths whose low 7 bits are 0 or above 64.
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_width_ff <= wft_pkg::PULSE_RESET;
         gap_width_ff <= wft_pkg::GAP_RESET;
         frame_bits_ff <= wft_pkg::FRAME_BITS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            wft_pkg::CSR_PULSE_WIDTH: begin
               if (csr_data != '0) pulse_width_ff <= csr_data[wft_pkg::PULSE_W-1:0];
            end
            wft_pkg::CSR_GAP_WIDTH: begin
               if (csr_data != '0) gap_width_ff <= csr_data[wft_pkg::GAP_W-1:0];
            end
            wft_pkg::CSR_FRAME_BITS: begin
               if (csr_data[wft_pkg::FRAME_BITS_W-1:0] != '0 &&
                   csr_data[wft_pkg::FRAME_BITS_W-1:0] <= wft_pkg::FRAME_BITS_W'(MAXB))
                  frame_bits_ff <= csr_data[wft_pkg::FRAME_BITS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Next state of the sequencer and its counters.
   always_comb begin
      phase_in = phase_ff;
      shift_word_in = shift_word_ff;
      bits_left_in = bits_left_ff;
      time_left_in = time_left_ff;
      done_in = 1'b0;
      ignored_in = 1'b0;
      if (req_operation == wft_pkg::OP_START) begin
         if (busy_now) begin
            ignored_in = 1'b1;
         end else begin
            shift_word_in = req_frame_value[MAXB-1:0] << shift_amt;
            bits_left_in = start_bits;
            phase_in = wft_pkg::PHASE_PULSE;
            time_left_in = pulse_width_ff;
         end
      end else begin
         unique case (phase_ff)
            wft_pkg::PHASE_PULSE: begin
               time_left_in = time_dec;
               if (time_dec == '0) begin
                  phase_in = wft_pkg::PHASE_GAP;
                  time_left_in = gap_width_ff;
               end
            end
            wft_pkg::PHASE_GAP: begin
               time_left_in = time_dec;
               if (time_dec == '0) begin
                  bits_left_in = bits_left_ff - BW'(1);
                  shift_word_in = {shift_word_ff[MAXB-2:0], 1'b0};
                  if (bits_left_ff == BW'(1)) begin
                     phase_in = wft_pkg::PHASE_IDLE;
                     done_in = 1'b1;
                  end else begin
                     phase_in = wft_pkg::PHASE_PULSE;
                     time_left_in = pulse_width_ff;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Line levels follow the state after this word.
   always_comb begin
      zero_line_in = !((phase_in == wft_pkg::PHASE_PULSE) && !shift_word_in[MAXB-1]);
      one_line_in = !((phase_in == wft_pkg::PHASE_PULSE) && shift_word_in[MAXB-1]);
      busy_in = (phase_in == wft_pkg::PHASE_PULSE) || (phase_in == wft_pkg::PHASE_GAP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= wft_pkg::PHASE_IDLE;
         shift_word_ff <= '0;
         bits_left_ff <= '0;
         time_left_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         shift_word_ff <= shift_word_in;
         bits_left_ff <= bits_left_in;
         time_left_ff <= time_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         zero_line_ff <= zero_line_in;
         one_line_ff <= one_line_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
         ignored_ff <= ignored_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_zero_line = zero_line_ff;
   assign rsp_one_line = one_line_ff;
   assign rsp_busy_res = busy_ff;
   assign rsp_frame_done = done_ff;
   assign rsp_start_ignored = ignored_ff;

   a_lines_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_zero_line || rsp_one_line))
      else $error("both data lines driven low");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |-> (!rsp_busy_res && !rsp_start_ignored))
      else $error("frame end reported while still busy");

   a_ignored_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_start_ignored) |-> rsp_busy_res)
      else $error("dropped start reported while idle");

   a_idle_no_bits: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == wft_pkg::PHASE_IDLE) |-> (bits_left_ff == '0))
      else $error("bits left while idle");

   a_busy_timer: assert property (@(posedge clock) disable iff (reset)
      busy_now |-> (time_left_ff != '0 && bits_left_ff != '0))
      else $error("busy with an empty timer or bit count");

endmodule
